### rtl/core/periodic_callback_timer_scheduler_core_macros.svh
// Assertion macros for the timer scheduler core.
`ifndef PERIODIC_CALLBACK_TIMER_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_CALLBACK_TIMER_SCHEDULER_CORE_MACROS_SVH
// Implication checked at every edge outside reset.
`define PCTS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked on the following edge.
`define PCTS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/core/pcts_pkg.sv
// Shared codes and constants of the timer scheduler.
`timescale 1ns / 1ps
package pcts_pkg;
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_REPLY    = 2'd2;

    localparam logic [2:0] K_ADDED = 3'd0;
    localparam logic [2:0] K_FULL  = 3'd1;
    localparam logic [2:0] K_FIRE  = 3'd2;
    localparam logic [2:0] K_DONE  = 3'd3;
    localparam logic [2:0] K_ERROR = 3'd4;

    localparam int SEQ_BITS = 16;
endpackage

### rtl/core/pcts_entry_ram.sv
// Entry store: one synchronous memory holding every timer record.
`timescale 1ns / 1ps
module pcts_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/core/periodic_callback_timer_scheduler_core.sv
`timescale 1ns / 1ps
// Timer queue core. All timers sit in one entry memory (one registered read port, one write
// port). An add or an error beat has its result ready on the cycle after it is taken; the
// next beat is taken only once that result has left the output register. A dispatch scans
// every queued entry through the memory read port, one entry a cycle, to find the first
// entry (unstarted first, then earliest due, then oldest); each unstarted entry found is
// scheduled with a write-back and the scan repeats. A reply that keeps its entry passes the
// write-back state and a settle state before the dispatch scan; one that removes its entry
// reads the last entry, copies it over its own and then settles before the scan. One item
// is in work at a time; the result waits in an output register and a new item is taken
// once it is gone.
module periodic_callback_timer_scheduler_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 48,
    parameter int ID_BITS     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata from bit 0: opcode, handler_id, interval_ticks, now_time, reply_delay
    input  logic [((2+ID_BITS+3*TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata from bit 0: result_kind, fired_id, elapsed_ticks, next_due, queue_empty
    output logic [((3+ID_BITS+2*TIME_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import pcts_pkg::*;
    `include "periodic_callback_timer_scheduler_core_macros.svh"

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 3 * TIME_BITS + ID_BITS + 1 + SEQ_BITS;
    localparam int OW = ((3 + ID_BITS + 2 * TIME_BITS + 7) / 8) * 8;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef struct packed {
        logic [TIME_BITS-1:0] due;
        logic [TIME_BITS-1:0] last;
        logic [TIME_BITS-1:0] period;
        logic [ID_BITS-1:0]   id;
        logic                 started;
        logic [SEQ_BITS-1:0]  seq;
    } t_entry;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_FIRE  = 4'd3;
    localparam logic [3:0] S_RDP   = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_RDL   = 4'd6;
    localparam logic [3:0] S_CPY   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_RDP2  = 4'd9;

    logic [3:0]            r_state;
    logic [CW-1:0]         r_count;
    logic                  r_await;
    logic [TIME_BITS-1:0]  r_dtime, r_earliest;
    logic [SEQ_BITS-1:0]   r_addc;
    logic [AW-1:0]         r_pend;
    logic [CW-1:0]         r_ridx;   // next address issued
    logic [CW-1:0]         r_cidx;   // address of data now on the read port
    logic                  r_rvalid;
    t_entry                r_best;
    logic [AW-1:0]         r_bidx;
    logic                  r_hbest;
    logic [TIME_BITS-1:0]  r_reply;
    logic                  r_ovalid;
    logic [2:0]            r_kind;
    logic [ID_BITS-1:0]    r_fid;
    logic [TIME_BITS-1:0]  r_el;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    t_entry                wdata, rdata;

    pcts_entry_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [1:0]           in_op;
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_iv, in_now, in_rep;
    assign in_op  = s_axis_tdata[1:0];
    assign in_id  = s_axis_tdata[2 +: ID_BITS];
    assign in_iv  = s_axis_tdata[2+ID_BITS +: TIME_BITS];
    assign in_now = s_axis_tdata[2+ID_BITS+TIME_BITS +: TIME_BITS];
    assign in_rep = s_axis_tdata[2+ID_BITS+2*TIME_BITS +: TIME_BITS];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    // candidate on read port beats current best
    logic cand_first;
    logic [SEQ_BITS-1:0] age_c, age_b;
    always_comb begin
        age_c = r_addc - rdata.seq;
        age_b = r_addc - r_best.seq;
        if (!r_hbest) cand_first = 1'b1;
        else if (rdata.started != r_best.started) cand_first = !rdata.started;
        else if (rdata.started && rdata.due != r_best.due) cand_first = rdata.due < r_best.due;
        else cand_first = age_c > age_b;
    end

    logic [TIME_BITS:0] el_diff;
    assign el_diff = {1'b0, r_dtime} - {1'b0, r_best.last};

    always_comb begin
        we = 1'b0;
        waddr = r_bidx;
        wdata = r_best;
        raddr = r_ridx[AW-1:0];
        if (acc) begin
            raddr = r_pend;
            if (in_op == OP_ADD && r_count < CW'(QUEUE_DEPTH)) begin
                we = 1'b1;
                waddr = r_count[AW-1:0];
                wdata.due = '0;
                wdata.last = '0;
                wdata.period = (in_iv == '0) ? TIME_BITS'(1) : in_iv;
                wdata.id = in_id;
                wdata.started = 1'b0;
                wdata.seq = r_addc;
            end
        end else if (r_state == S_DEC && !r_best.started) begin
            we = 1'b1;
            wdata.started = 1'b1;
            wdata.last = r_dtime;
            wdata.due = sat_add(r_dtime, r_best.period);
        end else if (r_state == S_UPD) begin
            we = 1'b1;
            waddr = r_pend;
            wdata = rdata;
            wdata.last = r_dtime;
            wdata.due = sat_add(r_dtime, (r_reply == '0) ? rdata.period : r_reply);
        end else if (r_state == S_RDL) begin
            raddr = AW'(r_count - CW'(1));
        end else if (r_state == S_CPY) begin
            we = 1'b1;
            waddr = r_pend;
            wdata = rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_await <= 1'b0;
            r_dtime <= '0;
            r_earliest <= '0;
            r_addc <= '0;
            r_pend <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_hbest <= 1'b0;
            r_ridx <= '0;
            r_cidx <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_kind <= K_ERROR;
                    r_fid <= '0;
                    r_el <= '0;
                    r_reply <= in_rep;
                    if (in_op == OP_ADD) begin
                        r_ovalid <= 1'b1;
                        if (r_count < CW'(QUEUE_DEPTH)) begin
                            r_kind <= K_ADDED;
                            r_count <= r_count + CW'(1);
                            r_addc <= r_addc + SEQ_BITS'(1);
                        end else r_kind <= K_FULL;
                    end else if (in_op == OP_DISPATCH && !r_await) begin
                        r_dtime <= in_now;
                        r_ridx <= '0;
                        r_rvalid <= 1'b0;
                        r_hbest <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (in_op == OP_REPLY && r_await
                                 && CW'(r_pend) < r_count) begin
                        r_await <= 1'b0;
                        if (in_rep[TIME_BITS-1]) r_state <= S_RDL;
                        else r_state <= S_UPD;
                    end else r_ovalid <= 1'b1;
                end
                S_UPD: begin
                    r_ridx <= '0; r_rvalid <= 1'b0; r_hbest <= 1'b0;
                    r_state <= S_RDP;
                end
                S_RDL: r_state <= S_CPY;
                S_CPY: begin
                    r_count <= r_count - CW'(1);
                    r_ridx <= '0; r_rvalid <= 1'b0; r_hbest <= 1'b0;
                    r_state <= S_RDP;
                end
                S_RDP: r_state <= S_SCAN;  // lets the write-back settle
                S_SCAN: begin
                    if (r_count == '0) begin
                        r_kind <= K_DONE; r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        if (r_rvalid && cand_first) begin
                            r_best <= rdata;
                            r_bidx <= r_cidx[AW-1:0];
                            r_hbest <= 1'b1;
                        end
                        r_cidx <= r_ridx;
                        if (r_ridx < r_count) begin
                            r_ridx <= r_ridx + CW'(1);
                            r_rvalid <= 1'b1;
                        end else begin
                            r_rvalid <= 1'b0;
                            if (!r_rvalid) r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_ridx <= '0; r_rvalid <= 1'b0; r_hbest <= 1'b0;
                    if (!r_best.started) r_state <= S_RDP2;
                    else if (r_best.due <= r_dtime) begin
                        r_await <= 1'b1;
                        r_pend <= r_bidx;
                        r_kind <= K_FIRE;
                        r_fid <= r_best.id;
                        r_el <= el_diff[TIME_BITS] ? '0 : el_diff[TIME_BITS-1:0];
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_earliest <= r_best.due;
                        r_kind <= K_DONE;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RDP2: r_state <= S_SCAN;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = OW'({(r_count == '0), r_earliest, r_el, r_fid, r_kind});

    `PCTS_ASSERT_IMP(a_busy_no_out, i_clk, i_rst_n, r_state != S_IDLE, !r_ovalid)
    `PCTS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `PCTS_ASSERT_NEXT(a_fire_waits, i_clk, i_rst_n,
        r_state == S_DEC && r_best.started && r_best.due <= r_dtime, r_await)
endmodule
